### hdl/rita_pkg.sv
// ----------------------------------------------------------------------------
// rita_pkg: shared types and constants for the radix integer to ASCII core
// Holds the job descriptor, the back-end state type, the character constants
// and the digit-to-character function.
// ----------------------------------------------------------------------------
package rita_pkg;

	// A base never exceeds 36, so six bits hold any base or digit.
	localparam int BASE_W = 6;
	localparam int CHAR_W = 7;
	// Dividend bits consumed per cycle by the digit divider.
	localparam int DIGIT_STEP = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] MIN_BASE = 8'd2;
	localparam logic [BASE_W-1:0] DEFAULT_BASE = 6'd10;
	localparam logic [BASE_W-1:0] LETTER_BASE = 6'd10;

	localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CH_UPPER = 7'h41;
	localparam logic [CHAR_W-1:0] CH_LOWER = 7'h61;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

	// Classified job, without the magnitude whose width is a parameter.
	typedef struct packed {
		logic neg;
		logic upper;
		logic [BASE_W-1:0] base;
	} rita_job_t;

	localparam int JOB_W = $bits(rita_job_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_CHECK,
		ST_SIGN,
		ST_EMIT
	} rita_state_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d,
		input logic up);
		logic [CHAR_W-1:0] letter_base;
		letter_base = up ? CH_UPPER : CH_LOWER;
		if (d < LETTER_BASE) begin
			return CH_ZERO + CHAR_W'(d);
		end
		return letter_base + CHAR_W'(d - LETTER_BASE);
	endfunction

endpackage

### hdl/rita_front.sv
// ----------------------------------------------------------------------------
// rita_front: input stage of the radix integer to ASCII core
// Accepts an input transfer, takes the magnitude and sign of the value and
// replaces an unusable base with base 10, then offers the job to the queue.
// ----------------------------------------------------------------------------
module rita_front #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_BASE = 36
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [7:0] base,
	input  logic upper_case,
	output logic job_valid,
	input  logic job_ready,
	output logic [VALUE_WIDTH-1:0] job_mag,
	output rita_pkg::rita_job_t job
);
	import rita_pkg::*;

	logic valid_s1;
	logic [VALUE_WIDTH-1:0] mag_s1;
	rita_job_t job_s1;
	rita_job_t job_c;

	assign in_ready = !valid_s1 || job_ready;

	always_comb begin
		job_c.neg = value[VALUE_WIDTH-1];
		job_c.upper = upper_case;
		if (base < MIN_BASE || base > 8'(MAX_BASE)) begin
			job_c.base = DEFAULT_BASE;
		end else begin
			job_c.base = base[BASE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mag_s1 <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
			job_s1 <= job_c;
		end
	end

	assign job_valid = valid_s1;
	assign job_mag = mag_s1;
	assign job = job_s1;

endmodule

### hdl/rita_queue.sv
// ----------------------------------------------------------------------------
// rita_queue: short job queue between front and back end
// A small register FIFO so that the front end keeps taking items while the
// back end is busy converting.
// ----------------------------------------------------------------------------
module rita_queue #(
	parameter int W = 46
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  logic [W-1:0] push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output logic [W-1:0] pop_data
);
	import rita_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hdl/rita_back.sv
// ----------------------------------------------------------------------------
// rita_back: digit engine of the radix integer to ASCII core
// Divides the magnitude by the base repeatedly, stacking the remainders, then
// sends the sign if negative, then the stacked digits most significant first.
// ----------------------------------------------------------------------------
module rita_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  logic [VALUE_WIDTH-1:0] job_mag,
	input  rita_pkg::rita_job_t job,
	output logic out_valid,
	input  logic out_ready,
	output logic [rita_pkg::CHAR_W-1:0] out_char,
	output logic out_last
);
	import rita_pkg::*;

	localparam int DIV_W = ((VALUE_WIDTH + DIGIT_STEP - 1) / DIGIT_STEP) * DIGIT_STEP;
	localparam int STEPS = DIV_W / DIGIT_STEP;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	rita_state_t state_q;
	rita_state_t state_d;

	logic [DIV_W-1:0] div_q;
	logic [BASE_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0] cnt_q;
	logic [BASE_W-1:0] stack_q [VALUE_WIDTH];
	rita_job_t job_q;

	logic out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic out_last_q;

	logic out_free;
	logic step_last;
	logic div_done;
	logic take_job;
	logic push_digit;
	logic pop_digit;
	logic load_out;

	logic [BASE_W:0] r;
	logic [DIGIT_STEP-1:0] top_bits;
	logic [DIGIT_STEP-1:0] qbits;
	logic [BASE_W-1:0] rem_next;
	logic [DIV_W-1:0] div_next;

	assign out_free = !out_valid_q || out_ready;
	assign step_last = step_q == STEP_W'(STEPS - 1);
	assign div_done = (div_q == '0) || (cnt_q == CNT_W'(VALUE_WIDTH));

	// One slice of restoring division: eight quotient bits per cycle, with the
	// running remainder always below the base.
	always_comb begin
		top_bits = div_q[DIV_W-1 -: DIGIT_STEP];
		r = {1'b0, rem_q};
		qbits = '0;
		for (int i = DIGIT_STEP - 1; i >= 0; i--) begin
			r = {r[BASE_W-1:0], top_bits[i]};
			if (r >= {1'b0, job_q.base}) begin
				r = r - {1'b0, job_q.base};
				qbits[i] = 1'b1;
			end
		end
		rem_next = r[BASE_W-1:0];
		div_next = (div_q << DIGIT_STEP) | DIV_W'(qbits);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (step_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (div_done) begin
					state_d = job_q.neg ? ST_SIGN : ST_EMIT;
				end else begin
					state_d = ST_DIVIDE;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free && cnt_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		take_job = 1'b0;
		push_digit = 1'b0;
		pop_digit = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: take_job = job_valid;
			ST_DIVIDE: push_digit = step_last;
			ST_CHECK: ;
			ST_SIGN: load_out = out_free;
			ST_EMIT: begin
				load_out = out_free;
				pop_digit = out_free;
			end
			default: ;
		endcase
	end

	assign job_ready = take_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take_job || state_q == ST_CHECK) begin
				step_q <= '0;
			end else if (state_q == ST_DIVIDE) begin
				step_q <= step_q + 1'b1;
			end
			if (take_job) begin
				cnt_q <= '0;
			end else if (push_digit) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_digit) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_job) begin
			div_q <= DIV_W'(job_mag);
			job_q <= job;
			rem_q <= '0;
		end else if (state_q == ST_DIVIDE) begin
			div_q <= div_next;
			rem_q <= rem_next;
		end else if (state_q == ST_CHECK) begin
			rem_q <= '0;
		end
		if (push_digit) begin
			stack_q[0] <= rem_next;
			for (int i = 1; i < VALUE_WIDTH; i++) begin
				stack_q[i] <= stack_q[i-1];
			end
		end else if (pop_digit) begin
			for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
				stack_q[i] <= stack_q[i+1];
			end
		end
		if (load_out) begin
			if (state_q == ST_SIGN) begin
				out_char_q <= CH_MINUS;
				out_last_q <= 1'b0;
			end else begin
				out_char_q <= digit_char(stack_q[0], job_q.upper);
				out_last_q <= cnt_q == CNT_W'(1);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign out_last = out_last_q;

endmodule

### hdl/radix_integer_to_ascii_core.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_core: signed integer to ASCII string in any base
// Converts a signed value to its digits in base 2..MAX_BASE, sign first, one
// character per output transfer, last character marked by tlast.
// ----------------------------------------------------------------------------
// Usage:
// An input transfer on s_axis carries the value, the base and the letter-case
// flag. A base below 2 or above MAX_BASE converts in base 10. The output
// stream on m_axis gives '-' first for a negative value, then the
// digits most significant first; zero gives the single character '0'.
// Timing: the front stage registers the classified item and hands it to a
// two-entry queue, so up to three items can be taken while the digit engine
// is busy. The engine divides by the base with a restoring divider that
// consumes eight dividend bits per cycle, running the divide steps over the
// whole dividend and then a check for each digit; the characters then leave
// at one per cycle while m_axis_tready stays high.
// Reset clears the front stage, the queue and the engine; nothing is lost but
// items in flight. When m_axis_tready is low the current character holds and
// the engine waits, while the front end keeps filling the queue until full.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii_core #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_BASE = 36,
	localparam int IN_TDATA_W = ((VALUE_WIDTH + 9 + 7) / 8) * 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// Fields from bit 0: value (VALUE_WIDTH), base (8), upper_case (1), zero fill.
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// Fields from bit 0: char_code (7), zero fill (1).
	output logic [7:0] m_axis_tdata,
	output logic m_axis_tlast
);
	import rita_pkg::*;

	localparam int QW = VALUE_WIDTH + JOB_W;

	logic [VALUE_WIDTH-1:0] in_value;
	logic [7:0] in_base;
	logic in_upper;

	// Front stage to queue.
	logic fq_valid;
	logic fq_ready;
	logic [VALUE_WIDTH-1:0] fq_mag;
	rita_job_t fq_job;

	// Queue to digit engine.
	logic qb_valid;
	logic qb_ready;
	logic [QW-1:0] qb_data;
	rita_job_t qb_job;
	logic [VALUE_WIDTH-1:0] qb_mag;

	logic [CHAR_W-1:0] char_code;

	assign in_value = s_axis_tdata[VALUE_WIDTH-1:0];
	assign in_base = s_axis_tdata[VALUE_WIDTH +: 8];
	assign in_upper = s_axis_tdata[VALUE_WIDTH + 8];

	rita_front #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.MAX_BASE(MAX_BASE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.value(in_value),
		.base(in_base),
		.upper_case(in_upper),
		.job_valid(fq_valid),
		.job_ready(fq_ready),
		.job_mag(fq_mag),
		.job(fq_job)
	);

	rita_queue #(
		.W(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data({fq_mag, fq_job}),
		.pop_valid(qb_valid),
		.pop_ready(qb_ready),
		.pop_data(qb_data)
	);

	assign qb_job = qb_data[JOB_W-1:0];
	assign qb_mag = qb_data[QW-1:JOB_W];

	rita_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(qb_valid),
		.job_ready(qb_ready),
		.job_mag(qb_mag),
		.job(qb_job),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_char(char_code),
		.out_last(m_axis_tlast)
	);

	// The character sits in the low seven bits; the top bit is fill.
	assign m_axis_tdata = {1'b0, char_code};

endmodule
